>>> rtl/stable_descending_sort_rank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_DESCENDING_SORT_RANK_ASSERT_SVH
`define STABLE_DESCENDING_SORT_RANK_ASSERT_SVH

// same-cycle implication
`define SDSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdsr_pkg.sv
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared types and field widths for the stable descending sort block.
// ----------------------------------------------------------------------------
package sdsr_pkg;

  localparam int KEY_W  = 32;
  localparam int ID_W   = 6;
  localparam int RANK_W = 7;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic             mark;
  } entry_t;

endpackage

>>> rtl/sdsr_entry_ram.sv
// ----------------------------------------------------------------------------
// sdsr_entry_ram
// Entry table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdsr_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sdsr_pkg::entry_t      wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sdsr_pkg::entry_t      rd_data
);

  sdsr_pkg::entry_t mem [DEPTH];
  sdsr_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/stable_descending_sort_rank.sv
// ----------------------------------------------------------------------------
// stable_descending_sort_rank
// Collects up to MAX_ENTRIES entries and emits them sorted by key, highest
// first, equal keys in arrival order, each tagged with the marked rank.
// ----------------------------------------------------------------------------
// Each entry is inserted into a sorted table held in one RAM: a scan from the
// tail reads one entry per cycle and shifts it down one slot until the new
// key's place is found. An entry into an empty table is written directly with
// no scan; for any other entry busy is high until its insertion is done.
// An entry arriving to a full table is dropped and flags the run. After the
// entry with in_last_entry, the table drains one result per cycle on
// out_valid; the results are never held back and must be taken as they come.
// The first result follows the last entry's insertion through the drain state
// and the registered read, and busy stays high until the final read is issued.
// ----------------------------------------------------------------------------
module stable_descending_sort_rank #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sdsr_pkg::KEY_W-1:0]  in_entry_key,
  input  logic [sdsr_pkg::ID_W-1:0]   in_entry_id,
  input  logic                        in_is_marked,
  input  logic                        in_last_entry,
  output logic                        out_valid,
  output logic [sdsr_pkg::KEY_W-1:0]  out_sorted_key,
  output logic [sdsr_pkg::ID_W-1:0]   out_sorted_id,
  output logic                        out_sorted_marked,
  output logic [sdsr_pkg::RANK_W-1:0] out_marked_rank,
  output logic                        out_overflowed,
  output logic                        out_last_result
);

`include "stable_descending_sort_rank_assert.svh"

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INS   = 2'd1;
  localparam logic [1:0] ST_PUT   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             mv_r, mv_nxt;
  logic [IDX_W-1:0] mpos_r, mpos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last_r, last_nxt;
  sdsr_pkg::entry_t new_r, new_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sdsr_pkg::RANK_W-1:0] rank_q_r, rank_q_nxt;
  logic                        ovf_q_r, ovf_q_nxt;
  logic                        last_q_r, last_q_nxt;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  sdsr_pkg::entry_t wr_data, rd_data, in_entry;

  logic             fin, fin_mark, fin_last;
  logic [IDX_W-1:0] fin_pos;
  logic             accept;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_entry = '{key: in_entry_key, id: in_entry_id, mark: in_is_marked};

  sdsr_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    mv_nxt        = mv_r;
    mpos_nxt      = mpos_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    new_nxt       = new_r;
    out_valid_nxt = 1'b0;
    rank_q_nxt    = rank_q_r;
    ovf_q_nxt     = ovf_q_r;
    last_q_nxt    = last_q_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = new_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    fin           = 1'b0;
    fin_pos       = '0;
    fin_mark      = new_r.mark;
    fin_last      = last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (count_r < CNT_W'(MAX_ENTRIES)) begin
            new_nxt  = in_entry;
            last_nxt = in_last_entry;
            if (count_r == '0) begin
              wr_en    = 1'b1;
              wr_addr  = '0;
              wr_data  = in_entry;
              fin      = 1'b1;
              fin_pos  = '0;
              fin_mark = in_is_marked;
              fin_last = in_last_entry;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(count_r - CNT_W'(1));
              idx_nxt   = IDX_W'(count_r - CNT_W'(1));
              state_nxt = ST_INS;
            end
          end else begin
            ovf_nxt = 1'b1;
            if (in_last_entry) begin
              idx_nxt   = '0;
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + IDX_W'(1);
        if (rd_data.key < new_r.key) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - IDX_W'(1);
            idx_nxt = idx_r - IDX_W'(1);
          end
        end else begin
          wr_data = new_r;
          fin     = 1'b1;
          fin_pos = idx_r + IDX_W'(1);
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_r;
        fin     = 1'b1;
        fin_pos = '0;
      end
      ST_DRAIN: begin
        rd_en         = 1'b1;
        rd_addr       = idx_r;
        out_valid_nxt = 1'b1;
        ovf_q_nxt     = ovf_r;
        rank_q_nxt    = mv_r ? (sdsr_pkg::RANK_W'(mpos_r) + sdsr_pkg::RANK_W'(1))
                             : (sdsr_pkg::RANK_W'(count_r) + sdsr_pkg::RANK_W'(1));
        last_q_nxt    = (idx_r == IDX_W'(count_r - CNT_W'(1)));
        if (idx_r == IDX_W'(count_r - CNT_W'(1))) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          mv_nxt    = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      count_nxt = count_r + CNT_W'(1);
      if (fin_mark && (!mv_r || (fin_pos <= mpos_r))) begin
        mv_nxt   = 1'b1;
        mpos_nxt = fin_pos;
      end else if (mv_r && (mpos_r >= fin_pos)) begin
        mpos_nxt = mpos_r + IDX_W'(1);
      end
      idx_nxt   = '0;
      state_nxt = fin_last ? ST_DRAIN : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mpos_r   <= mpos_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
    new_r    <= new_nxt;
    rank_q_r <= rank_q_nxt;
    ovf_q_r  <= ovf_q_nxt;
    last_q_r <= last_q_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_key    = rd_data.key;
  assign out_sorted_id     = rd_data.id;
  assign out_sorted_marked = rd_data.mark;
  assign out_marked_rank   = rank_q_r;
  assign out_overflowed    = ovf_q_r;
  assign out_last_result   = last_q_r;

  `SDSR_ASSERT_NOW(a_no_rw_collision, wr_en && rd_en, wr_addr != rd_addr, "ram r/w clash")
  `SDSR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ENTRIES), "count overflow")
  `SDSR_ASSERT_NOW(a_mark_in_table, mv_r, CNT_W'(mpos_r) < count_r, "mark outside table")
  `SDSR_ASSERT_NEXT(a_drain_strobe, state_r == ST_DRAIN, out_valid, "missing strobe")
  `SDSR_ASSERT_NOW(a_last_strobed, out_last_result && out_valid, state_r != ST_DRAIN, "overrun")

endmodule
